// File: hw/rtl/bptz_pkg.sv
// Shared types and constants for the binomial power trailing zeros block.
package bptz_pkg;

	// Operand width: every input field is reduced to its low VALUE_BITS bits.
	localparam int VALUE_BITS = 32;
	localparam int FIELD_W    = 32;
	localparam int CNT_W      = 38;

	// Width of the multiplicity counter for one prime in a nonzero operand.
	localparam int VCNT_W = $clog2(VALUE_BITS);
	localparam int PROD_W = VCNT_W + VALUE_BITS;

	// Wide enough to hold the binomial term plus the power term without wrapping.
	localparam int SUM_W = ((PROD_W + 1) > (CNT_W + 1)) ? (PROD_W + 1) : (CNT_W + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Reciprocal of five, scaled by 2^(VALUE_BITS+2) and rounded up.
	localparam int RECIP_SHIFT = VALUE_BITS + 2;
	localparam logic [VALUE_BITS-1:0] RECIP5 =
		VALUE_BITS'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);

	typedef struct packed {
		logic [FIELD_W-1:0] n_total;
		logic [FIELD_W-1:0] r_chosen;
		logic [FIELD_W-1:0] base_value;
		logic [FIELD_W-1:0] exponent;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] zero_count;
		logic [CNT_W-1:0] twos_count;
		logic [CNT_W-1:0] fives_count;
		logic             invalid;
	} result_t;

endpackage

// File: hw/rtl/bptz_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface bptz_item_if;
	logic            valid;
	logic            ready;
	bptz_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bptz_result_if;
	logic              valid;
	logic              ready;
	bptz_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/binomial_power_trailing_zeros.sv
// Top level: trailing decimal zeros of C(n,r) * p^q, one shared divide-by-prime unit.
//
// Usage
//   items   : sink channel carrying n_total, r_chosen, base_value and exponent.
//   results : source channel carrying zero_count, twos_count, fives_count, invalid.
//   Each transaction on items produces exactly one transaction on results.
//   items.ready is high only while the sequencer is idle; one item is worked on at a time.
// Operation
//   A shared unit divides one operand by the current prime each cycle (a shift for two,
//   a reciprocal multiply for five). Per prime the factorial phase adds the successive
//   quotients of n and subtracts those of r and of n-r, each until the operand reaches zero;
//   then the valuation of p is counted, multiplied by the exponent and added to form the total.
//   results.valid rises in the same cycle as items.ready returns, when the hand-off completes;
//   a new item is not accepted until the previous one has reached its hand-off.
//   An invalid item (r > n or p == 0) goes straight to the hand-off, skipping the arithmetic.
// Reset and stalls
//   arst_n clears the sequencer and the result valid flag; no item is in flight afterwards.
//   The result register holds a finished result until results.ready; the next item is
//   accepted meanwhile and worked on, and only its final hand-off waits for the register.
module binomial_power_trailing_zeros (
	input  logic                 clk,
	input  logic                 arst_n,
	bptz_item_if.sink            items,
	bptz_result_if.source        results
);

	localparam int VB = bptz_pkg::VALUE_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_FACT = 6'b000010,
		ST_VAL  = 6'b000100,
		ST_MULT = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	// Which factorial of Legendre's formula is being summed.
	localparam logic [1:0] OP_N  = 2'd0;
	localparam logic [1:0] OP_R  = 2'd1;
	localparam logic [1:0] OP_NR = 2'd2;

	state_t                          st_q;
	logic                            prime5_q;
	logic [1:0]                      opnd_q;
	logic [VB-1:0]                   n_q, r_q, p_q, e_q;
	logic [VB-1:0]                   x_q;
	logic [VB-1:0]                   acc_q;
	logic [bptz_pkg::VCNT_W-1:0]     vcnt_q;
	logic [bptz_pkg::PROD_W-1:0]     prod_q;
	logic [bptz_pkg::CNT_W-1:0]      twos_q, fives_q;
	logic                            inv_q;
	logic                            out_v_q;
	bptz_pkg::result_t               res_q;

	logic [VB-1:0]                   in_n, in_r, in_p, in_e;
	logic                            in_bad;
	logic                            accept;
	logic [2*VB-1:0]                 recip_prod;
	logic [VB-1:0]                   quot;
	logic                            rem_zero;
	logic [bptz_pkg::SUM_W-1:0]      sum;
	logic [bptz_pkg::CNT_W-1:0]      total;
	logic [bptz_pkg::CNT_W-1:0]      min_cnt;
	logic                            out_free;

	// Operands reduced to the working width.
	assign in_n   = VB'(items.data.n_total);
	assign in_r   = VB'(items.data.r_chosen);
	assign in_p   = VB'(items.data.base_value);
	assign in_e   = VB'(items.data.exponent);
	assign in_bad = (in_r > in_n) || (in_p == '0);

	assign items.ready = (st_q == ST_IDLE);
	assign accept      = items.valid && items.ready;

	// Shared unit: quotient of x_q by the current prime and whether the remainder is zero.
	assign recip_prod = {{VB{1'b0}}, x_q} * {{VB{1'b0}}, bptz_pkg::RECIP5};
	always_comb begin
		if (prime5_q) begin
			quot     = VB'(recip_prod >> bptz_pkg::RECIP_SHIFT);
			rem_zero = (x_q == ((quot << 2) + quot));
		end else begin
			quot     = x_q >> 1;
			rem_zero = ~x_q[0];
		end
	end

	// Binomial term plus power term, saturated to the count width.
	assign sum   = bptz_pkg::SUM_W'(acc_q) + bptz_pkg::SUM_W'(prod_q);
	assign total = (sum > bptz_pkg::SUM_W'(bptz_pkg::COUNT_MAX)) ?
		bptz_pkg::COUNT_MAX : sum[bptz_pkg::CNT_W-1:0];

	assign min_cnt  = (twos_q < fives_q) ? twos_q : fives_q;
	assign out_free = !out_v_q || results.ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			prime5_q <= 1'b0;
			opnd_q   <= OP_N;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						prime5_q <= 1'b0;
						opnd_q   <= OP_N;
						st_q     <= in_bad ? ST_FIN : ST_FACT;
					end
				end
				ST_FACT: begin
					if (x_q == '0) begin
						unique case (opnd_q)
							OP_N:    opnd_q <= OP_R;
							OP_R:    opnd_q <= OP_NR;
							default: st_q   <= ST_VAL;
						endcase
					end
				end
				ST_VAL: begin
					if (!rem_zero) begin
						st_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					if (prime5_q) begin
						st_q <= ST_FIN;
					end else begin
						prime5_q <= 1'b1;
						opnd_q   <= OP_N;
						st_q     <= ST_FACT;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					n_q    <= in_n;
					r_q    <= in_r;
					p_q    <= in_p;
					e_q    <= in_e;
					x_q    <= in_n;
					acc_q  <= '0;
					inv_q  <= in_bad;
				end
			end
			ST_FACT: begin
				if (x_q == '0) begin
					unique case (opnd_q)
						OP_N:    x_q <= r_q;
						OP_R:    x_q <= n_q - r_q;
						default: begin
							x_q    <= p_q;
							vcnt_q <= '0;
						end
					endcase
				end else begin
					x_q   <= quot;
					acc_q <= (opnd_q == OP_N) ? acc_q + quot : acc_q - quot;
				end
			end
			ST_VAL: begin
				if (rem_zero) begin
					x_q    <= quot;
					vcnt_q <= vcnt_q + 1'b1;
				end
			end
			ST_MULT: begin
				prod_q <= bptz_pkg::PROD_W'(vcnt_q) * bptz_pkg::PROD_W'(e_q);
			end
			ST_ADD: begin
				if (prime5_q) begin
					fives_q <= total;
				end else begin
					twos_q <= total;
					x_q    <= n_q;
					acc_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	// Result register, held until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (st_q == ST_FIN && out_free) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && out_free) begin
			res_q.invalid     <= inv_q;
			res_q.zero_count  <= inv_q ? '0 : min_cnt;
			res_q.twos_count  <= inv_q ? '0 : twos_q;
			res_q.fives_count <= inv_q ? '0 : fives_q;
		end
	end

	assign results.valid = out_v_q;
	assign results.data  = res_q;

	// A finished result is never overwritten before it has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && out_v_q && !results.ready) |=> (st_q == ST_FIN))
		else $error("result register overwritten while stalled");

	// A rejected item skips the arithmetic entirely.
	a_invalid_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_bad) |=> (st_q == ST_FIN && inv_q))
		else $error("invalid item entered the arithmetic");

	// The valuation loop never sees zero, so it always ends.
	a_val_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_VAL) |-> (x_q != '0))
		else $error("valuation of a zero operand");

	// An invalid result carries zero counts.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.invalid) |->
		(results.data.zero_count == '0 && results.data.twos_count == '0 &&
		 results.data.fives_count == '0))
		else $error("invalid result with nonzero counts");

	// The second prime is only reached through the first prime's completion.
	a_prime_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(prime5_q) |-> ($past(st_q) == ST_ADD))
		else $error("prime five phase started out of order");

endmodule
